// ===== hw/rtl/chip8_core_subset_macros.svh =====
// Assertion helpers for the controller RTL; each expects clk_i and rst_ni in scope.
`ifndef CHIP8_CORE_SUBSET_MACROS_SVH
`define CHIP8_CORE_SUBSET_MACROS_SVH

// Same-cycle implication.
`define C8CS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("c8cs assertion failed");

// Next-cycle implication.
`define C8CS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("c8cs assertion failed");

`endif

// ===== hw/rtl/c8cs_pkg.sv =====
`default_nettype none
package c8cs_pkg;
  localparam int unsigned MemBytes     = 4096;
  localparam int unsigned ScreenWidth  = 64;
  localparam int unsigned ScreenHeight = 32;
  localparam int unsigned AddrW        = $clog2(MemBytes);
  localparam int unsigned RowW         = $clog2(ScreenHeight);
  localparam int unsigned ColW         = $clog2(ScreenWidth);

  localparam logic [AddrW-1:0] PcStart = 12'h200;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_EXEC  = 2'd1;
  localparam logic [1:0] REQ_PIXEL = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [3:0] OP_SYS   = 4'h0;
  localparam logic [3:0] OP_JUMP  = 4'h1;
  localparam logic [3:0] OP_SET   = 4'h6;
  localparam logic [3:0] OP_ADD   = 4'h7;
  localparam logic [3:0] OP_INDEX = 4'hA;
  localparam logic [3:0] OP_DRAW  = 4'hD;
  localparam logic [15:0] OpClear = 16'h00E0;

  typedef struct packed {
    logic clr_step;
    logic latch_in;
    logic mem_wr;
    logic fetch0;
    logic fetch1;
    logic fetch2;
    logic exec;
    logic drawy;
    logic row_rd;
    logic row_wr;
    logic pix0;
    logic pix1;
    logic load_out;
  } c8cs_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic [3:0] kind;
    logic       row_done;
    logic       clr_last;
    logic       out_free;
  } c8cs_stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/c8cs_ram.sv =====
`default_nettype none
module c8cs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/c8cs_ctrl.sv =====
`default_nettype none
`include "chip8_core_subset_macros.svh"
module c8cs_ctrl import c8cs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire c8cs_stat_t stat_i,
  output c8cs_cmd_t       cmd_o
);
  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_WRITE  = 13'b0000000000100,
    S_FETCH0 = 13'b0000000001000,
    S_FETCH1 = 13'b0000000010000,
    S_FETCH2 = 13'b0000000100000,
    S_EXEC   = 13'b0000001000000,
    S_DRAWY  = 13'b0000010000000,
    S_ROWRD  = 13'b0000100000000,
    S_ROWWR  = 13'b0001000000000,
    S_PIX0   = 13'b0010000000000,
    S_PIX1   = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          case (stat_i.req)
            REQ_WRITE: state_d = S_WRITE;
            REQ_EXEC:  state_d = S_FETCH0;
            REQ_PIXEL: state_d = S_PIX0;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_WRITE: begin
        cmd_o.mem_wr = 1'b1;
        state_d = S_DONE;
      end
      S_FETCH0: begin
        cmd_o.fetch0 = 1'b1;
        state_d = S_FETCH1;
      end
      S_FETCH1: begin
        cmd_o.fetch1 = 1'b1;
        state_d = S_FETCH2;
      end
      S_FETCH2: begin
        cmd_o.fetch2 = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = (stat_i.kind == OP_DRAW) ? S_DRAWY : S_DONE;
      end
      S_DRAWY: begin
        cmd_o.drawy = 1'b1;
        state_d = S_ROWRD;
      end
      S_ROWRD: begin
        if (stat_i.row_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.row_rd = 1'b1;
          state_d = S_ROWWR;
        end
      end
      S_ROWWR: begin
        cmd_o.row_wr = 1'b1;
        state_d = S_ROWRD;
      end
      S_PIX0: begin
        cmd_o.pix0 = 1'b1;
        state_d = S_PIX1;
      end
      S_PIX1: begin
        cmd_o.pix1 = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `C8CS_ASSERT_NEXT(a_fetch_to_exec, state_q == S_FETCH2, state_q == S_EXEC)
  `C8CS_ASSERT_NEXT(a_load_to_idle, cmd_o.load_out, state_q == S_IDLE)
  `C8CS_ASSERT_NEXT(a_no_reclear, state_q == S_IDLE, state_q != S_CLEAR)
  `C8CS_ASSERT_NOW(a_row_wr_after_rd, state_q == S_ROWWR, $past(cmd_o.row_rd))
endmodule
`default_nettype wire

// ===== hw/rtl/c8cs_dpath.sv =====
`default_nettype none
module c8cs_dpath import c8cs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire c8cs_cmd_t   cmd_i,
  output c8cs_stat_t       stat_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [11:0] mem_address_i,
  input  wire logic [7:0]  mem_data_i,
  input  wire logic [5:0]  pixel_x_i,
  input  wire logic [4:0]  pixel_y_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             pixel_value_o,
  output logic [11:0]      next_pc_o,
  output logic [15:0]      executed_opcode_o,
  output logic             unknown_opcode_o,
  output logic [7:0]       flag_register_o
);
  logic [AddrW-1:0] pc_q, idx_q, clr_cnt_q, addr_q;
  logic [7:0]       data_q;
  logic [ColW-1:0]  px_q, ox_q;
  logic [RowW-1:0]  py_q, oy_q, rowa_q;
  logic [15:0]      op_q;
  logic [3:0]       row_q;
  logic             unk_q, pix_q;
  logic [7:0]       v_q [16];
  logic [ScreenHeight-1:0] fv_q;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, mem_rdata;
  logic [ScreenWidth-1:0] fr_rdata, fr_old, fr_mask;
  logic [RowW-1:0]  fr_raddr;
  logic [RowW:0]    row_sum;
  logic [3:0]       rsel;
  logic [7:0]       rval, rev;
  logic             known;

  assign row_sum = {1'b0, oy_q} + {2'b0, row_q};
  assign rsel    = cmd_i.exec ? op_q[11:8] : op_q[7:4];
  assign rval    = v_q[rsel];

  always_comb begin
    mem_we    = cmd_i.clr_step | cmd_i.mem_wr;
    mem_waddr = cmd_i.clr_step ? clr_cnt_q : addr_q;
    mem_wdata = cmd_i.clr_step ? 8'h00 : data_q;
    if (cmd_i.fetch0) begin
      mem_raddr = pc_q;
    end else if (cmd_i.fetch1) begin
      mem_raddr = pc_q + AddrW'(1);
    end else begin
      mem_raddr = idx_q + AddrW'(row_q);
    end
    fr_raddr = cmd_i.pix0 ? py_q : row_sum[RowW-1:0];
  end

  c8cs_ram #(.Width(8), .Depth(MemBytes)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Sprite bit 7 is the leftmost pixel; frame bit n is column n.
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      rev[c] = mem_rdata[7-c];
    end
    fr_old  = fv_q[rowa_q] ? fr_rdata : '0;
    fr_mask = ScreenWidth'(rev) << ox_q;
  end

  c8cs_ram #(.Width(ScreenWidth), .Depth(ScreenHeight)) u_frame (
    .clk_i  (clk_i),
    .we_i   (cmd_i.row_wr),
    .waddr_i(rowa_q),
    .wdata_i(fr_old ^ fr_mask),
    .raddr_i(fr_raddr),
    .rdata_o(fr_rdata)
  );

  always_comb begin
    case (op_q[15:12]) inside
      OP_SYS:  known = (op_q == OpClear);
      OP_JUMP, OP_SET, OP_ADD, OP_INDEX, OP_DRAW: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign stat_o.req      = req_type_i;
  assign stat_o.kind     = op_q[15:12];
  assign stat_o.row_done = (row_q == op_q[3:0]) || row_sum[RowW];
  assign stat_o.clr_last = (clr_cnt_q == '1);
  assign stat_o.out_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PcStart;
      idx_q       <= '0;
      clr_cnt_q   <= '0;
      fv_q        <= '0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        v_q[i] <= '0;
      end
    end else begin
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + AddrW'(1);
      end
      if (cmd_i.fetch2) begin
        pc_q <= pc_q + AddrW'(2);
      end
      if (cmd_i.exec) begin
        case (op_q[15:12])
          OP_SYS: begin
            if (op_q == OpClear) begin
              fv_q <= '0;
            end
          end
          OP_JUMP:  pc_q <= op_q[11:0];
          OP_SET:   v_q[op_q[11:8]] <= op_q[7:0];
          OP_ADD:   v_q[op_q[11:8]] <= rval + op_q[7:0];
          OP_INDEX: idx_q <= op_q[11:0];
          default: ;
        endcase
      end
      if (cmd_i.drawy) begin
        v_q[15] <= '0;
      end
      if (cmd_i.row_wr) begin
        fv_q[rowa_q] <= 1'b1;
        if ((fr_old & fr_mask) != '0) begin
          v_q[15] <= 8'd1;
        end
      end
      if (cmd_i.load_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      addr_q <= mem_address_i;
      data_q <= mem_data_i;
      px_q   <= pixel_x_i;
      py_q   <= pixel_y_i;
      op_q   <= '0;
      unk_q  <= 1'b0;
      pix_q  <= 1'b0;
    end
    if (cmd_i.fetch1) begin
      op_q[15:8] <= mem_rdata;
    end
    if (cmd_i.fetch2) begin
      op_q[7:0] <= mem_rdata;
    end
    if (cmd_i.exec) begin
      unk_q <= !known;
      ox_q  <= rval[ColW-1:0];
    end
    if (cmd_i.drawy) begin
      oy_q  <= rval[RowW-1:0];
      row_q <= '0;
    end
    if (cmd_i.row_rd) begin
      rowa_q <= row_sum[RowW-1:0];
    end
    if (cmd_i.row_wr) begin
      row_q <= row_q + 4'd1;
    end
    if (cmd_i.pix0) begin
      rowa_q <= py_q;
    end
    if (cmd_i.pix1) begin
      pix_q <= fv_q[rowa_q] & fr_rdata[px_q];
    end
    if (cmd_i.load_out) begin
      pixel_value_o     <= pix_q;
      next_pc_o         <= pc_q;
      executed_opcode_o <= op_q;
      unknown_opcode_o  <= unk_q;
      flag_register_o   <= v_q[15];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/chip8_core_subset.sv =====
// Channel   Direction  tdata fields (lowest bit first)
// s_axis    in         req_type, mem_address, mem_data, pixel_x, pixel_y
// m_axis    out        pixel_value, next_pc, executed_opcode, unknown_opcode,
//                      flag_register
// After reset a clearing pass zeroes the 4096-byte memory; no input is taken during it.
// From acceptance to a valid result: a memory write passes the write state, a pixel read
// two pixel states, an instruction fetch and execute, a draw also a read and write per row.
// The registered sprite memory read and frame row read-modify-write set the row rate.
// A finished result waits in the output register; the next item is accepted meanwhile.
`default_nettype none
module chip8_core_subset import c8cs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // req_type, mem_address, mem_data, pixel_x, pixel_y
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // pixel_value, next_pc, opcode, unknown, flag
);
  c8cs_cmd_t   cmd;
  c8cs_stat_t  stat;
  logic        pix;
  logic [11:0] npc;
  logic [15:0] opc;
  logic        unk;
  logic [7:0]  flg;

  c8cs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  c8cs_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .req_type_i       (s_axis_tdata[1:0]),
    .mem_address_i    (s_axis_tdata[13:2]),
    .mem_data_i       (s_axis_tdata[21:14]),
    .pixel_x_i        (s_axis_tdata[27:22]),
    .pixel_y_i        (s_axis_tdata[32:28]),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .pixel_value_o    (pix),
    .next_pc_o        (npc),
    .executed_opcode_o(opc),
    .unknown_opcode_o (unk),
    .flag_register_o  (flg)
  );

  assign m_axis_tdata = {2'b00, flg, unk, opc, npc, pix};
endmodule
`default_nettype wire
